// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the quadratic smoothing gradient RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QSG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define QSG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/qsg_pkg.sv =====
// Package for the quadratic smoothing gradient block: widths, constants and types.
// Used by the channel interfaces, the result FIFO, the register port and the top level.
package qsg_pkg;

   localparam int EST_W       = 16;
   localparam int LAM_W       = 16;
   localparam int GRAD_W      = 40;
   localparam int OBJ_W       = 63;
   localparam int SUM_W       = 64;
   localparam int TERM_W      = 50;
   localparam int FIFO_DEPTH  = 16;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = FIFO_AW + 1;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [LAM_W-1:0] LAM_RESET = 16'd256;
   localparam logic             CSR_IDX_SMOOTHING_WEIGHT = 1'b0;

   typedef struct packed {
      logic signed [GRAD_W-1:0] gradient;
      logic [OBJ_W-1:0]         objective;
      logic                     last_out;
   } rsp_entry_type;

   typedef struct packed {
      logic valid0;
      logic valid1;
   } push_ctrl_type;

   typedef struct packed {
      logic [FIFO_CW-1:0] level;
      logic               head_valid;
   } fifo_status_type;

endpackage

// ===== hw/rtl/qsg_req_if.sv =====
// Input channel interface: valid/ready handshake with estimate, observed and is_last.
// Depends on qsg_pkg for field widths.
interface qsg_req_if import qsg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [EST_W-1:0] estimate;
   logic signed [EST_W-1:0] observed;
   logic                    is_last;

   modport source (output valid, output estimate, output observed, output is_last,
                   input ready);
   modport sink (input valid, input estimate, input observed, input is_last,
                 output ready);
endinterface

// ===== hw/rtl/qsg_rsp_if.sv =====
// Result channel interface: valid/ready handshake with gradient, objective and last_out.
// Depends on qsg_pkg for field widths.
interface qsg_rsp_if import qsg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [GRAD_W-1:0] gradient;
   logic [OBJ_W-1:0]         objective;
   logic                     last_out;

   modport source (output valid, output gradient, output objective, output last_out,
                   input ready);
   modport sink (input valid, input gradient, input objective, input last_out,
                 output ready);
endinterface

// ===== hw/rtl/qsg_csr.sv =====
// APB-style register port holding the smoothing weight.
// Depends on qsg_pkg.
module qsg_csr import qsg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output logic [LAM_W-1:0]  smoothing_weight
);

   logic [LAM_W-1:0] weight_ff;
   logic [LAM_W-1:0] weight_in;
   logic             reg_index;
   logic             wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_AW-1];
   assign wr_en     = psel & penable & pwrite & pready;

   always_comb begin
      weight_in = weight_ff;
      unique case (reg_index)
         CSR_IDX_SMOOTHING_WEIGHT: begin
            if (wr_en) begin
               weight_in = pwdata[LAM_W-1:0];
            end
         end
         default: begin
            weight_in = weight_ff;
         end
      endcase
   end

   always_comb begin
      unique case (reg_index)
         CSR_IDX_SMOOTHING_WEIGHT: prdata = CSR_DW'(weight_ff);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= LAM_RESET;
      end else begin
         weight_ff <= weight_in;
      end
   end

   assign smoothing_weight = weight_ff;

endmodule

// ===== hw/rtl/qsg_rsp_fifo.sv =====
// Result FIFO that takes up to two entries per cycle and releases one per transfer.
// Depends on qsg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qsg_rsp_fifo import qsg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_ctrl_type   push,
   input  rsp_entry_type   push_data0,
   input  rsp_entry_type   push_data1,
   input  logic            pop,
   output rsp_entry_type   head,
   output fifo_status_type status
);

   rsp_entry_type        entries_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   wr_ptr_in;
   logic [FIFO_AW-1:0]   wr_ptr_next1;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_in;
   logic [FIFO_CW-1:0]   level_ff;
   logic [FIFO_CW-1:0]   level_in;
   logic                 do_pop;

   assign do_pop       = pop & (level_ff != '0);
   assign wr_ptr_next1 = wr_ptr_ff + FIFO_AW'(1);
   assign wr_ptr_in    = wr_ptr_ff + FIFO_AW'(push.valid0) + FIFO_AW'(push.valid1);
   assign rd_ptr_in    = rd_ptr_ff + FIFO_AW'(do_pop);
   assign level_in     = level_ff + FIFO_CW'(push.valid0) + FIFO_CW'(push.valid1)
                         - FIFO_CW'(do_pop);

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entries_ff[wr_ptr_ff] <= push_data0;
      end
      if (push.valid1) begin
         entries_ff[wr_ptr_next1] <= push_data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head              = entries_ff[rd_ptr_ff];
   assign status.level      = level_ff;
   assign status.head_valid = (level_ff != '0);

   `QSG_ASSERT_IMPL(a_fifo_no_overflow, push.valid0, (level_ff + FIFO_CW'(push.valid0) + FIFO_CW'(push.valid1)) <= FIFO_CW'(FIFO_DEPTH), "Result FIFO overflow.")
   `QSG_ASSERT_IMPL(a_fifo_push_order, push.valid1, push.valid0, "Second push slot used without the first.")
   `QSG_ASSERT_IMPL(a_fifo_ptr_level, 1'b1, FIFO_AW'(wr_ptr_ff - rd_ptr_ff) == level_ff[FIFO_AW-1:0], "FIFO pointers disagree with level.")

endmodule

// ===== hw/rtl/quadratic_smoothing_gradient_top.sv =====
// Quadratic smoothing gradient: one vector element (estimate, observed, is_last) is taken
// per clock, and each gradient element leaves once the next element has arrived, so the
// final element of a vector yields two results, the second carrying the objective value;
// a single-element vector yields only the result with the objective. Elements pass a
// three-stage pipeline (input register, products, sums) into a 16-entry result FIFO; the
// objective accumulator in the last stage feeds back through one register, so a new
// element is accepted every cycle while the FIFO has room for everything still in flight.
// Depends on qsg_pkg, qsg_req_if, qsg_rsp_if, qsg_csr, qsg_rsp_fifo and assert_macros.svh.
`include "assert_macros.svh"
module quadratic_smoothing_gradient_top import qsg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   qsg_req_if.sink           req_ch,
   qsg_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam logic [1:0] FILL_EMPTY = 2'd0;
   localparam logic [1:0] FILL_ONE   = 2'd1;
   localparam logic [1:0] FILL_TWO   = 2'd2;

   logic [LAM_W-1:0] lam;

   qsg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .smoothing_weight (lam)
   );

   // Stage 1: input register and neighbor state.
   logic                    accept;
   logic                    credit_ok;
   logic [1:0]              inflight;
   fifo_status_type         fifo_status;

   logic                    s1_valid_ff;
   logic                    s2_valid_ff;
   logic                    s3_valid_ff;
   logic signed [EST_W-1:0] s1_estimate_ff;
   logic signed [EST_W-1:0] s1_observed_ff;
   logic                    s1_last_ff;

   logic [1:0]              fill_ff;
   logic [1:0]              fill_in;
   logic signed [EST_W-1:0] held_est_ff;
   logic signed [EST_W-1:0] held_est_in;
   logic signed [EST_W-1:0] older_est_ff;
   logic signed [EST_W-1:0] older_est_in;
   logic signed [EST_W-1:0] held_obs_ff;
   logic signed [EST_W-1:0] held_obs_in;

   assign inflight  = 2'(s1_valid_ff) + 2'(s2_valid_ff) + 2'(s3_valid_ff);
   assign credit_ok = (6'(fifo_status.level) + 6'(inflight) * 6'd2 + 6'd2)
                      <= 6'(FIFO_DEPTH);
   assign req_ch.ready = credit_ok;
   assign accept       = req_ch.valid & credit_ok;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_estimate_ff <= req_ch.estimate;
         s1_observed_ff <= req_ch.observed;
         s1_last_ff     <= req_ch.is_last;
      end
   end

   always_comb begin
      fill_in      = fill_ff;
      held_est_in  = held_est_ff;
      older_est_in = older_est_ff;
      held_obs_in  = held_obs_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            fill_in      = FILL_EMPTY;
            held_est_in  = '0;
            older_est_in = '0;
            held_obs_in  = '0;
         end else begin
            fill_in      = (fill_ff == FILL_EMPTY) ? FILL_ONE : FILL_TWO;
            older_est_in = held_est_ff;
            held_est_in  = s1_estimate_ff;
            held_obs_in  = s1_observed_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fill_ff      <= FILL_EMPTY;
         held_est_ff  <= '0;
         older_est_ff <= '0;
         held_obs_ff  <= '0;
      end else begin
         s1_valid_ff  <= accept;
         fill_ff      <= fill_in;
         held_est_ff  <= held_est_in;
         older_est_ff <= older_est_in;
         held_obs_ff  <= held_obs_in;
      end
   end

   logic signed [16:0] dxy;
   logic signed [16:0] dxh;
   logic signed [16:0] dhh;
   logic signed [18:0] dgrad;
   logic signed [16:0] lam_s;
   logic signed [35:0] prod_g1;
   logic signed [33:0] prod_g2;
   logic signed [33:0] prod_fit;
   logic signed [33:0] prod_sm;

   assign dxy   = 17'(s1_estimate_ff) - 17'(s1_observed_ff);
   assign dxh   = 17'(s1_estimate_ff) - 17'(held_est_ff);
   assign dhh   = 17'(held_est_ff) - 17'(held_obs_ff);
   assign dgrad = 19'(held_est_ff) - 19'(s1_estimate_ff)
                  + ((fill_ff == FILL_TWO) ? (19'(held_est_ff) - 19'(older_est_ff)) : 19'sd0);
   assign lam_s    = $signed({1'b0, lam});
   assign prod_g1  = 36'(dgrad) * 36'(lam_s);
   assign prod_g2  = dxh * lam_s;
   assign prod_fit = dxy * dxy;
   assign prod_sm  = dxh * dxh;

   // Stage 2: products registered, then gradient sums and the objective term.
   logic                    s2_emit1_ff;
   logic                    s2_last_ff;
   logic                    s2_first_ff;
   logic signed [16:0]      s2_dxy_ff;
   logic signed [16:0]      s2_dhh_ff;
   logic signed [35:0]      s2_prod_g1_ff;
   logic signed [33:0]      s2_prod_g2_ff;
   logic [32:0]             s2_fit_ff;
   logic [32:0]             s2_sm_ff;
   logic [LAM_W-1:0]        s2_lam_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_emit1_ff   <= (fill_ff != FILL_EMPTY);
         s2_last_ff    <= s1_last_ff;
         s2_first_ff   <= (fill_ff == FILL_EMPTY);
         s2_dxy_ff     <= dxy;
         s2_dhh_ff     <= dhh;
         s2_prod_g1_ff <= prod_g1;
         s2_prod_g2_ff <= prod_g2;
         s2_fit_ff     <= prod_fit[32:0];
         s2_sm_ff      <= prod_sm[32:0];
         s2_lam_ff     <= lam;
      end
   end

   logic signed [GRAD_W-1:0] grad1;
   logic signed [GRAD_W-1:0] grad2;
   logic signed [GRAD_W-1:0] fit_grad;
   logic [48:0]              smooth_term;
   logic [TERM_W-1:0]        obj_term;

   assign fit_grad    = GRAD_W'(s2_dxy_ff) <<< 9;
   assign grad1       = (GRAD_W'(s2_dhh_ff) <<< 9) + (GRAD_W'(s2_prod_g1_ff) <<< 1);
   assign grad2       = s2_first_ff ? fit_grad : fit_grad + (GRAD_W'(s2_prod_g2_ff) <<< 1);
   assign smooth_term = 49'(s2_sm_ff) * 49'(s2_lam_ff);
   assign obj_term    = s2_first_ff ? (TERM_W'(s2_fit_ff) << 8)
                                    : (TERM_W'(s2_fit_ff) << 8) + TERM_W'(smooth_term);

   // Stage 3: objective accumulation and FIFO write.
   logic                     s3_emit1_ff;
   logic                     s3_last_ff;
   logic                     s3_first_ff;
   logic signed [GRAD_W-1:0] s3_grad1_ff;
   logic signed [GRAD_W-1:0] s3_grad2_ff;
   logic [TERM_W-1:0]        s3_term_ff;

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_emit1_ff <= s2_emit1_ff;
         s3_last_ff  <= s2_last_ff;
         s3_first_ff <= s2_first_ff;
         s3_grad1_ff <= grad1;
         s3_grad2_ff <= grad2;
         s3_term_ff  <= obj_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum_next;

   assign sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(s3_term_ff);
   assign sum_next = s3_first_ff ? SUM_W'(s3_term_ff)
                   : (sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0]);
   assign sum_in   = s3_valid_ff ? sum_next : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   rsp_entry_type entry_mid;
   rsp_entry_type entry_end;
   rsp_entry_type push_data0;
   push_ctrl_type push;

   assign entry_mid.gradient  = s3_grad1_ff;
   assign entry_mid.objective = '0;
   assign entry_mid.last_out  = 1'b0;
   assign entry_end.gradient  = s3_grad2_ff;
   assign entry_end.objective = OBJ_W'(sum_next[SUM_W-1:8]);
   assign entry_end.last_out  = 1'b1;

   assign push.valid0 = s3_valid_ff & (s3_emit1_ff | s3_last_ff);
   assign push.valid1 = s3_valid_ff & s3_emit1_ff & s3_last_ff;
   assign push_data0  = s3_emit1_ff ? entry_mid : entry_end;

   rsp_entry_type head;

   qsg_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (push_data0),
      .push_data1 (entry_end),
      .pop        (rsp_ch.ready),
      .head       (head),
      .status     (fifo_status)
   );

   assign rsp_ch.valid     = fifo_status.head_valid;
   assign rsp_ch.gradient  = head.gradient;
   assign rsp_ch.objective = head.objective;
   assign rsp_ch.last_out  = head.last_out;

   `QSG_ASSERT_NEXT(a_accept_loads_s1, accept, s1_valid_ff, "Accepted transfer did not reach the input register.")
   `QSG_ASSERT_IMPL(a_credit_bound, 1'b1, (6'(fifo_status.level) + 6'(inflight) * 6'd2) <= 6'(FIFO_DEPTH), "Results in flight exceed FIFO space.")
   `QSG_ASSERT_IMPL(a_first_has_no_mid, s3_valid_ff & s3_first_ff, !s3_emit1_ff, "First element produced a gradient for a missing predecessor.")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for quadratic_smoothing_gradient_top: random vectors under varied
// flow control, checked against an in-bench gradient and objective predictor.
// Depends on qsg_pkg, qsg_req_if, qsg_rsp_if and the block's RTL.
module testbench import qsg_pkg::*; ();

   localparam int CLOCK_PERIOD = 10;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS = 400;
   localparam logic [CSR_AW-1:0] WEIGHT_ADDR = {CSR_IDX_SMOOTHING_WEIGHT, 2'b00};
   localparam logic signed [EST_W-1:0] EST_MAX = 16'sh7FFF;
   localparam logic signed [EST_W-1:0] EST_MIN = 16'sh8000;
   localparam logic [LAM_W-1:0] WEIGHT_MAX = 16'hFFFF;

   class gradient_tracker;
      typedef enum logic [1:0] {NO_ELEMENT, FIRST_HELD, INNER_HELD} fill_state_type;
      localparam longint GRAD_HI = (longint'(1) <<< (GRAD_W - 1)) - 1;
      localparam longint GRAD_LO = -(longint'(1) <<< (GRAD_W - 1));

      logic [LAM_W-1:0] weight;
      longint held_est;
      longint older_est;
      longint held_obs;
      longint unsigned objective_acc;
      fill_state_type fill;
      rsp_entry_type pending_gradients[$];
      int errors;

      function new();
         weight = LAM_RESET;
         errors = 0;
         clear_vector();
      endfunction

      function void clear_vector();
         held_est = 0;
         older_est = 0;
         held_obs = 0;
         objective_acc = 0;
         fill = NO_ELEMENT;
      endfunction

      function void set_weight(logic [LAM_W-1:0] w);
         weight = w;
      endfunction

      function int pending();
         return pending_gradients.size();
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
      endfunction

      function longint unsigned add_capped(longint unsigned a, longint unsigned b);
         return (a > ~b) ? '1 : a + b;
      endfunction

      function void queue_result(longint g, longint unsigned obj, logic last);
         rsp_entry_type e;
         if (g > GRAD_HI)
            g = GRAD_HI;
         else if (g < GRAD_LO)
            g = GRAD_LO;
         e.gradient = GRAD_W'(g);
         e.objective = OBJ_W'(obj);
         e.last_out = last;
         pending_gradients.push_back(e);
      endfunction

      function void note_element(logic signed [EST_W-1:0] est, logic signed [EST_W-1:0] obs,
                                 logic last);
         longint x;
         longint y;
         longint lam;
         longint d;
         longint unsigned fit;
         longint unsigned smooth;
         x = est;
         y = obs;
         lam = longint'(weight);
         fit = longint'((x - y) * (x - y)) * 256;
         if (fill == NO_ELEMENT) begin
            objective_acc = fit;
            if (last) begin
               queue_result((x - y) * 512, objective_acc >> 8, 1'b1);
               clear_vector();
            end else begin
               held_est = x;
               held_obs = y;
               fill = FIRST_HELD;
            end
            return;
         end
         d = held_est - x;
         if (fill == INNER_HELD)
            d += held_est - older_est;
         queue_result((held_est - held_obs) * 512 + 2 * lam * d, 0, 1'b0);
         smooth = longint'((x - held_est) * (x - held_est)) * lam;
         objective_acc = add_capped(objective_acc, fit);
         objective_acc = add_capped(objective_acc, smooth);
         if (last) begin
            queue_result((x - y) * 512 + 2 * lam * (x - held_est), objective_acc >> 8, 1'b1);
            clear_vector();
            return;
         end
         older_est = held_est;
         held_est = x;
         held_obs = y;
         fill = INNER_HELD;
      endfunction

      function void check_result(logic signed [GRAD_W-1:0] g, logic [OBJ_W-1:0] obj,
                                 logic last);
         rsp_entry_type want;
         if (pending_gradients.size() == 0) begin
            flag($sformatf("unexpected result: gradient %0d objective %0d last_out %0b",
                           g, obj, last));
            return;
         end
         want = pending_gradients.pop_front();
         if (g !== want.gradient)
            flag($sformatf("gradient expected %0d, got %0d", want.gradient, g));
         if (obj !== want.objective)
            flag($sformatf("objective expected %0d, got %0d", want.objective, obj));
         if (last !== want.last_out)
            flag($sformatf("last_out expected %0b, got %0b", want.last_out, last));
      endfunction

      function void finish_check();
         if (pending_gradients.size() != 0)
            flag($sformatf("%0d expected results never arrived", pending_gradients.size()));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   int send_idle_pct;
   int rsp_stall_pct;
   int hold_off_cycles;
   gradient_tracker board;

   qsg_req_if req_link ();
   qsg_rsp_if result_link ();

   quadratic_smoothing_gradient_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_link),
      .rsp_ch  (result_link),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      #(CLOCK_PERIOD * 2000000);
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver normally stalls at random; a requested hold-off is counted out here.
   initial begin
      result_link.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            result_link.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else begin
            result_link.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (result_link.valid && result_link.ready)
            board.check_result(result_link.gradient, result_link.objective,
                               result_link.last_out);
         if (req_link.valid && req_link.ready)
            board.note_element(req_link.estimate, req_link.observed, req_link.is_last);
      end
   end

   function automatic logic signed [EST_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return EST_MAX;
         1: return EST_MIN;
         2: return '0;
         default: return EST_W'($urandom);
      endcase
   endfunction

   task automatic send_element(input logic signed [EST_W-1:0] est,
                               input logic signed [EST_W-1:0] obs, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_link.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_link.valid <= 1'b1;
      req_link.estimate <= est;
      req_link.observed <= obs;
      req_link.is_last <= last;
      do @(posedge clock); while (!req_link.ready);
   endtask

   task automatic send_vector(input int len);
      for (int i = 0; i < len; i++)
         send_element(pick_sample(), pick_sample(), i == len - 1);
   endtask

   task automatic drain();
      req_link.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(input logic [LAM_W-1:0] w);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= WEIGHT_ADDR;
      pwdata <= CSR_DW'(w);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_weight(w);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[LAM_W-1:0] !== w)
         board.flag($sformatf("weight read back %0d, written %0d", prdata[LAM_W-1:0], w));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int sent;
      int len;
      board = new();
      reset = 1'b1;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_cycles = 0;
      req_link.valid = 1'b0;
      req_link.estimate = '0;
      req_link.observed = '0;
      req_link.is_last = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-element vectors and a short vector at the reset weight.
      send_element(EST_MAX, EST_MIN, 1'b1);
      send_element(EST_MIN, EST_MAX, 1'b1);
      send_element('0, '0, 1'b1);
      send_element(16'sh0100, 16'sh0080, 1'b0);
      send_element(16'shFF00, 16'sh0000, 1'b0);
      send_element(16'sh0200, 16'sh0300, 1'b1);
      drain();

      // Alternating extremes at the largest weight give the largest gradients.
      write_weight(WEIGHT_MAX);
      send_element(EST_MIN, EST_MAX, 1'b0);
      send_element(EST_MAX, EST_MIN, 1'b0);
      send_element(EST_MIN, EST_MAX, 1'b1);
      send_element(EST_MAX, EST_MIN, 1'b0);
      send_element(EST_MIN, EST_MAX, 1'b1);
      drain();

      write_weight('0);
      send_vector(4);
      drain();

      // The weight changes while a vector is half way through.
      send_element(EST_MAX, 16'sh1234, 1'b0);
      send_element(EST_MIN, 16'shEDCB, 1'b0);
      drain();
      write_weight(16'd1);
      send_element(16'sh4000, EST_MIN, 1'b0);
      send_element(EST_MAX, EST_MAX, 1'b1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               write_weight(LAM_W'($urandom));
            end
            1: begin
               send_idle_pct = 83;
               rsp_stall_pct = 0;
               write_weight(WEIGHT_MAX);
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 83;
               write_weight('0);
            end
            default: begin
               send_idle_pct = 8;
               rsp_stall_pct = 8;
               write_weight(LAM_W'($urandom));
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
            send_vector(len);
            sent += len;
         end
         drain();
      end

      // Results back up behind a long receiver hold-off until the input stalls.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_weight(LAM_W'($urandom));
      hold_off_cycles = 300;
      sent = 0;
      while (sent < 80) begin
         len = $urandom_range(6, 1);
         send_vector(len);
         sent += len;
      end
      drain();

      board.finish_check();
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/qsg_pkg.sv
hw/rtl/qsg_req_if.sv
hw/rtl/qsg_rsp_if.sv
hw/rtl/qsg_csr.sv
hw/rtl/qsg_rsp_fifo.sv
hw/rtl/quadratic_smoothing_gradient_top.sv
test/testbench.sv
